// File: rtl/assert_macros.svh
// assertion macros for the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock while out of reset
`define STP_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("stp check failed");

// same-cycle implication
`define STP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stp check failed");

`endif

// File: rtl/stp_pkg.sv
// types and constants of the spanning tree bpdu engine
package stp_pkg;

    typedef struct packed {
        logic        mode;
        logic [2:0]  rx_port;
        logic [63:0] msg_root;
        logic [31:0] msg_cost;
        logic [63:0] msg_bridge;
        logic [15:0] msg_port;
    } stp_in_t;

    typedef struct packed {
        logic [2:0]  tx_port;
        logic [63:0] tx_root;
        logic [31:0] tx_cost;
        logic [63:0] tx_bridge;
        logic [15:0] tx_port_ident;
        logic        last;
    } stp_out_t;

    // priority vector, field order gives lexicographic order
    typedef struct packed {
        logic [63:0] root;
        logic [31:0] cost;
        logic [63:0] bridge;
        logic [15:0] ident;
    } stp_vec_t;

    localparam logic [1:0] REG_BRIDGE_ID     = 2'd0;
    localparam logic [1:0] REG_PORTS_IN_USE  = 2'd1;
    localparam logic [1:0] REG_LINK_COST     = 2'd2;
    localparam logic [1:0] REG_PORT_PRIORITY = 2'd3;

    localparam logic       MODE_MSG   = 1'b0;
    localparam logic       MODE_HELLO = 1'b1;

    localparam int unsigned MAX_TX = 8;

endpackage

// File: rtl/stp_cmp.sv
// shared lexicographic compare unit for priority vectors
module stp_cmp (
    input  stp_pkg::stp_vec_t a,
    input  stp_pkg::stp_vec_t b,
    output logic              a_better
);
    import stp_pkg::*;

    // smaller is better, root first then cost, bridge, port
    assign a_better = (a < b);

endmodule

// File: rtl/stp_port_tbl.sv
// per-port priority vector store with one read port and valid bits
module stp_port_tbl #(
    parameter int PORTS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic                     wr_en,
    input  logic [$clog2(PORTS)-1:0] wr_idx,
    input  stp_pkg::stp_vec_t        wr_vec,
    input  logic [$clog2(PORTS)-1:0] rd_idx,
    input  logic [63:0]              own_bridge,
    input  logic [7:0]               prio,
    output stp_pkg::stp_vec_t        rd_vec
);
    import stp_pkg::*;

    stp_vec_t         vec_reg [PORTS];
    logic [PORTS-1:0] valid_reg;
    logic [7:0]       own_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vec_reg[wr_idx] <= wr_vec;
        end
    end

    // an unwritten entry reads as the port's reset vector
    assign own_low = 8'(rd_idx) + 8'd1;

    always_comb
    begin
        if (valid_reg[rd_idx])
        begin
            rd_vec = vec_reg[rd_idx];
        end
        else
        begin
            rd_vec.root   = own_bridge;
            rd_vec.cost   = '0;
            rd_vec.bridge = own_bridge;
            rd_vec.ident  = {prio, own_low};
        end
    end

endmodule

// File: rtl/spanning_tree_bpdu_engine.sv
// top level of the spanning tree configuration bpdu engine
// usage:
//   input channel in_valid/in_stall/in_data carries one beat per received
//   configuration message (mode 0) or hello tick (mode 1)
//   output channel out_valid/out_stall/out_data carries one beat per
//   designated port, in port order, last set on the final beat of a run
//   apb port writes bridge_id (0x00), ports_in_use (0x08), link_cost (0x10)
//   and port_priority (0x18); any write reinitializes the port state
// sequence:
//   a message, taken in the idle state, walks the port table one entry a
//   cycle through a single read port and a single shared vector comparator:
//   a compare step that drops a message worse than the stored entry, a scan
//   of the active ports, a root step, a refresh pass, then, unless the bridge
//   is root, an emit pass with one beat per designated port, up to eight
//   a hello tick, while hello runs, takes the idle state, a refresh pass and emission
//   in_stall is high while an item is in work
// reset: all ports designated for the bridge itself, hello running, no beat
// stall: the output register holds its beat; emission pauses until taken
module spanning_tree_bpdu_engine #(
    parameter int PORTS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  stp_pkg::stp_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output stp_pkg::stp_out_t out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import stp_pkg::*;

    `include "assert_macros.svh"

    localparam int IW = $clog2(PORTS);
    localparam int CW = $clog2(PORTS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_SCAN = 6'b000100,
        S_ROOT = 6'b001000,
        S_UPD  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    // configuration registers
    logic [63:0] bridge_id_reg;
    logic [3:0]  ports_in_use_reg;
    logic [15:0] link_cost_reg;
    logic [7:0]  port_priority_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // sequencer state
    state_t           state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             tick_reg, tick_next;
    logic             hello_reg, hello_next;
    logic             have_best_reg, have_best_next;
    stp_vec_t         best_vec_reg, best_vec_next;
    stp_vec_t         msg_reg, msg_next;
    logic [63:0]      best_root_reg, best_root_next;
    logic [31:0]      best_cost_reg, best_cost_next;
    logic [PORTS-1:0] mask_reg, mask_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    stp_out_t         out_reg, out_next;

    // datapath
    logic [CW-1:0] n_act;
    logic [IW-1:0] last_idx;
    stp_vec_t      rd_vec;
    stp_vec_t      cmp_b;
    logic          a_better;
    logic          desig;
    logic [7:0]    own_low;
    logic          tbl_wr;
    stp_vec_t      tbl_wr_vec;
    logic [32:0]   cost_sum;
    logic          can_load;
    logic          tx_last;
    logic          accept;
    logic [PORTS-1:0] idx_bit;

    // apb write and read
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_BRIDGE_ID:     prdata = bridge_id_reg;
            REG_PORTS_IN_USE:  prdata = 64'(ports_in_use_reg);
            REG_LINK_COST:     prdata = 64'(link_cost_reg);
            REG_PORT_PRIORITY: prdata = 64'(port_priority_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_id_reg     <= '0;
            ports_in_use_reg  <= 4'd8;
            link_cost_reg     <= 16'd1;
            port_priority_reg <= 8'd128;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BRIDGE_ID:     bridge_id_reg     <= pwdata;
                REG_PORTS_IN_USE:  ports_in_use_reg  <= pwdata[3:0];
                REG_LINK_COST:     link_cost_reg     <= pwdata[15:0];
                REG_PORT_PRIORITY: port_priority_reg <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // active port count, zero counts as one, clipped to the table size
    always_comb
    begin
        if (ports_in_use_reg == 4'd0)
        begin
            n_act = CW'(1);
        end
        else if ({1'b0, ports_in_use_reg} > 5'(PORTS))
        begin
            n_act = CW'(PORTS);
        end
        else
        begin
            n_act = CW'(ports_in_use_reg);
        end
    end
    assign last_idx = IW'(n_act - CW'(1));

    // port table, read at the sequencer index only
    stp_port_tbl #(
        .PORTS (PORTS)
    ) u_tbl (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cfg_wr),
        .wr_en      (tbl_wr),
        .wr_idx     (idx_reg),
        .wr_vec     (tbl_wr_vec),
        .rd_idx     (idx_reg),
        .own_bridge (bridge_id_reg),
        .prio       (port_priority_reg),
        .rd_vec     (rd_vec)
    );

    // one comparator: stored entry against the message, or against the running best
    assign cmp_b = (state_reg == S_CMP) ? msg_reg : best_vec_reg;

    stp_cmp u_cmp (
        .a        (rd_vec),
        .b        (cmp_b),
        .a_better (a_better)
    );

    // designated: entry still carries our bridge and the port's own id
    assign own_low = 8'(idx_reg) + 8'd1;
    assign desig   = (rd_vec.bridge == bridge_id_reg)
                  && (rd_vec.ident == {port_priority_reg, own_low});

    assign cost_sum = {1'b0, best_vec_reg.cost} + 33'(link_cost_reg);
    assign can_load = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign idx_bit  = PORTS'(1) << idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        hello_next     = hello_reg;
        have_best_next = have_best_reg;
        best_vec_next  = best_vec_reg;
        msg_next       = msg_reg;
        best_root_next = best_root_reg;
        best_cost_next = best_cost_reg;
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        tbl_wr         = 1'b0;
        tbl_wr_vec     = rd_vec;
        tx_last        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    msg_next.root   = in_data.msg_root;
                    msg_next.cost   = in_data.msg_cost;
                    msg_next.bridge = in_data.msg_bridge;
                    msg_next.ident  = in_data.msg_port;
                    if (in_data.mode == MODE_HELLO)
                    begin
                        // refresh pass doubles as the designated-port survey
                        if (hello_reg)
                        begin
                            tick_next  = 1'b1;
                            idx_next   = '0;
                            mask_next  = '0;
                            state_next = S_UPD;
                        end
                    end
                    else if ({2'b0, in_data.rx_port} < 5'(n_act))
                    begin
                        tick_next  = 1'b0;
                        idx_next   = IW'(in_data.rx_port);
                        state_next = S_CMP;
                    end
                end
            end

            S_CMP:
            begin
                if (a_better)
                begin
                    // stored vector strictly better, message dropped
                    state_next = S_IDLE;
                end
                else
                begin
                    tbl_wr         = 1'b1;
                    tbl_wr_vec     = msg_reg;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!desig && (!have_best_reg || a_better))
                begin
                    have_best_next = 1'b1;
                    best_vec_next  = rd_vec;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            S_ROOT:
            begin
                if (have_best_reg)
                begin
                    best_root_next = best_vec_reg.root;
                    best_cost_next = cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];
                end
                else
                begin
                    best_root_next = bridge_id_reg;
                    best_cost_next = '0;
                end
                idx_next   = '0;
                mask_next  = '0;
                state_next = S_UPD;
            end

            S_UPD:
            begin
                if (desig)
                begin
                    tbl_wr          = 1'b1;
                    tbl_wr_vec.root = best_root_reg;
                    tbl_wr_vec.cost = best_cost_reg;
                    mask_next       = mask_reg | idx_bit;
                end
                if (idx_reg == last_idx)
                begin
                    idx_next = '0;
                    cnt_next = '0;
                    if (tick_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (best_root_reg == bridge_id_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        hello_next = 1'b0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            S_EMIT:
            begin
                if (mask_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (mask_reg[idx_reg])
                begin
                    if (can_load)
                    begin
                        tx_last = ((mask_reg & ~idx_bit) == '0)
                               || (cnt_reg == 4'(MAX_TX - 1));
                        out_valid_next         = 1'b1;
                        out_next.tx_port       = 3'(idx_reg);
                        out_next.tx_root       = best_root_reg;
                        out_next.tx_cost       = best_cost_reg;
                        out_next.tx_bridge     = bridge_id_reg;
                        out_next.tx_port_ident = rd_vec.ident;
                        out_next.last          = tx_last;
                        mask_next              = mask_reg & ~idx_bit;
                        cnt_next               = cnt_reg + 4'd1;
                        if (tx_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration write reinitializes the derived state
        if (cfg_wr)
        begin
            hello_next     = 1'b1;
            best_cost_next = '0;
            best_root_next = (cfg_idx == REG_BRIDGE_ID) ? pwdata : bridge_id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            tick_reg       <= 1'b0;
            hello_reg      <= 1'b1;
            have_best_reg  <= 1'b0;
            best_root_reg  <= '0;
            best_cost_reg  <= '0;
            mask_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            tick_reg       <= tick_next;
            hello_reg      <= hello_next;
            have_best_reg  <= have_best_next;
            best_root_reg  <= best_root_next;
            best_cost_reg  <= best_cost_next;
            mask_reg       <= mask_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_vec_reg <= best_vec_next;
        msg_reg      <= msg_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // never more than eight beats in one run
    `STP_ASSERT_IMP(a_emit_bound, state_reg == S_EMIT, cnt_reg < 4'(MAX_TX))
    // hello only stops at the start of an emission run
    `STP_ASSERT_IMP(a_hello_stop, $fell(hello_reg), state_reg == S_EMIT)
    // no new item is taken while a run is in work
    `STP_ASSERT(a_busy_stall, (state_reg == S_IDLE) || in_stall)

endmodule
